/* sv/pmm_pkg.sv */
package pmm_pkg;

  localparam int NUM_COEFFS_DEF = 8;
  localparam int VAL_W          = 64;
  localparam int LAM_W          = 16;

  // item kinds
  localparam logic [2:0] KIND_LOAD_A  = 3'd0;
  localparam logic [2:0] KIND_LOAD_B  = 3'd1;
  localparam logic [2:0] KIND_LOAD_G  = 3'd2;
  localparam logic [2:0] KIND_LOAD_G1 = 3'd3;
  localparam logic [2:0] KIND_START   = 3'd4;

  // sign treatment of the two 64-bit factors
  typedef enum logic [1:0] {
    MODE_UU,
    MODE_SU,
    MODE_SS
  } mac_mode_t;

  typedef struct packed {
    logic      start;
    mac_mode_t mode;
  } mac_ctrl_t;

endpackage

/* sv/pmm_mac.sv */
module pmm_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmm_pkg::mac_ctrl_t           ctrl,
  input  logic [pmm_pkg::VAL_W-1:0]    opa,
  input  logic [pmm_pkg::VAL_W-1:0]    opb,
  output logic                         done,
  output logic [2*pmm_pkg::VAL_W-1:0]  prod
);

  localparam int W = pmm_pkg::VAL_W;
  localparam int H = W / 2;

  logic [W-1:0]      a_r, b_r;
  pmm_pkg::mac_mode_t mode_r;
  logic [2:0]        ph_r;
  logic              busy_r, done_r;
  logic [W-1:0]      pp_r;
  logic [2*W-1:0]    prod_r;
  logic [1:0]        q, q_prev;
  logic [H-1:0]      a_half, b_half;
  logic [2*W-1:0]    pp_shift;
  logic [W-1:0]      hi_fix;

  // pick the 32-bit halves for this partial product
  always_comb begin
    q      = ph_r[1:0];
    q_prev = 2'(ph_r - 3'd1);
    a_half = q[1] ? a_r[W-1:H] : a_r[H-1:0];
    b_half = q[0] ? b_r[W-1:H] : b_r[H-1:0];
    unique case (q_prev)
      2'd0:    pp_shift = {{W{1'b0}}, pp_r};
      2'd3:    pp_shift = {pp_r, {W{1'b0}}};
      default: pp_shift = {{H{1'b0}}, pp_r, {H{1'b0}}};
    endcase
  end

  // signed corrections on the upper half
  always_comb begin
    hi_fix = prod_r[2*W-1:W];
    unique case (mode_r)
      pmm_pkg::MODE_SS: begin
        if (a_r[W-1]) hi_fix = hi_fix - b_r;
        if (b_r[W-1]) hi_fix = hi_fix - a_r;
      end
      pmm_pkg::MODE_SU: begin
        if (a_r[W-1]) hi_fix = hi_fix - b_r;
      end
      default: hi_fix = prod_r[2*W-1:W];
    endcase
  end

  // four partial products, one add each, then sign fix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        a_r    <= opa;
        b_r    <= opb;
        mode_r <= ctrl.mode;
        prod_r <= '0;
        ph_r   <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ph_r < 3'd4) pp_r <= a_half * b_half;
        if (ph_r > 3'd0 && ph_r < 3'd5) prod_r <= prod_r + pp_shift;
        if (ph_r == 3'd5) begin
          prod_r[2*W-1:W] <= hi_fix;
          done_r          <= 1'b1;
          busy_r          <= 1'b0;
        end
        ph_r <= ph_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

/* sv/pmns_montgomery_multiply.sv */
// PMNS Montgomery multiplier. Load transactions (no result) fill operands A and
// B and the matrices G and G1; a start transaction computes R = A*B mod
// (X^N - lambda), T = low64(R*G1) and R += T*G, then returns N transactions
// holding the upper 64 bits of each R coefficient in index order, out_last on
// the final one. Every multiply-accumulate runs on one shared 32x32 multiplier
// in four partial products plus memory read and fix-up, and the output
// transactions wait for out_ready. Lambda (lam_r) is written through cfg_we
// and resets to 2; the user must write it only while idle, which the block
// does not enforce.
module pmns_montgomery_multiply #(
  parameter int NUM_COEFFS = pmm_pkg::NUM_COEFFS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [63:0] in_coefficient,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_index,
  output logic signed [63:0] out_value,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);

  localparam int W  = pmm_pkg::VAL_W;
  localparam int IW = $clog2(NUM_COEFFS);
  localparam int AW = $clog2(NUM_COEFFS * NUM_COEFFS);
  localparam logic [IW-1:0] LAST = IW'(NUM_COEFFS - 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_LAM, S_MAC, S_ENDI, S_OUT} state_t;
  typedef enum logic [1:0] {ST_PROD, ST_QUOT, ST_RED} step_t;

  state_t state_r;
  step_t  step_r;
  logic [IW-1:0] i_r, j_r;
  logic [pmm_pkg::LAM_W-1:0] lam_r;
  logic [2*W-1:0] acc_r;
  logic out_valid_r, out_last_r;
  logic [2:0] out_index_r;
  logic [W-1:0] out_value_r;

  // memories
  logic [W-1:0]   mem_a  [NUM_COEFFS];
  logic [W-1:0]   mem_b  [NUM_COEFFS];
  logic [W-1:0]   mem_g  [NUM_COEFFS*NUM_COEFFS];
  logic [W-1:0]   mem_g1 [NUM_COEFFS*NUM_COEFFS];
  logic [2*W-1:0] mem_r  [NUM_COEFFS];
  logic [W-1:0]   mem_t  [NUM_COEFFS];
  logic [W-1:0]   a_rd_r, b_rd_r, g_rd_r, g1_rd_r, t_rd_r;
  logic [2*W-1:0] r_rd_r;

  logic in_acc, row_ok, col_ok;
  logic [IW-1:0] ld_idx, k_idx, r_addr;
  logic [AW-1:0] ld_addr, m_addr;
  logic [IW:0]   diff;
  logic          wrap;
  logic [79:0]   p16;
  logic [W-1:0]  lb;

  pmm_pkg::mac_ctrl_t mac_ctrl;
  logic [W-1:0]   mac_a, mac_b;
  logic           mac_done;
  logic [2*W-1:0] mac_prod;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign row_ok   = int'(in_row) < NUM_COEFFS;
  assign col_ok   = int'(in_col) < NUM_COEFFS;
  assign ld_idx   = IW'(in_row);
  assign ld_addr  = AW'(int'(in_row) * NUM_COEFFS + int'(in_col));

  // read addresses follow the loop counters
  always_comb begin
    diff   = {1'b0, i_r} - {1'b0, j_r};
    wrap   = j_r > i_r;
    k_idx  = wrap ? IW'(diff + (IW+1)'(NUM_COEFFS)) : IW'(diff);
    m_addr = AW'(int'(j_r) * NUM_COEFFS + int'(i_r));
    r_addr = (step_r == ST_RED) ? i_r : j_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == pmm_pkg::KIND_LOAD_A && row_ok) mem_a[ld_idx] <= in_coefficient;
    a_rd_r <= mem_a[j_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == pmm_pkg::KIND_LOAD_B && row_ok) mem_b[ld_idx] <= in_coefficient;
    b_rd_r <= mem_b[k_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == pmm_pkg::KIND_LOAD_G && row_ok && col_ok)
      mem_g[ld_addr] <= in_coefficient;
    g_rd_r <= mem_g[m_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == pmm_pkg::KIND_LOAD_G1 && row_ok && col_ok)
      mem_g1[ld_addr] <= in_coefficient;
    g1_rd_r <= mem_g1[m_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ENDI && step_r == ST_PROD) mem_r[i_r] <= acc_r;
    r_rd_r <= mem_r[r_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ENDI && step_r == ST_QUOT) mem_t[i_r] <= acc_r[W-1:0];
    t_rd_r <= mem_t[j_r];
  end

  // lambda * B[k] wrapped to 64 bits, lambda signed
  always_comb begin
    p16 = b_rd_r * lam_r;
    lb  = p16[W-1:0] - (lam_r[15] ? {b_rd_r[W-17:0], 16'd0} : {W{1'b0}});
  end

  // operand select per step
  always_comb begin
    mac_ctrl.start = (state_r == S_LAM);
    unique case (step_r)
      ST_PROD: begin
        mac_ctrl.mode = pmm_pkg::MODE_SS;
        mac_a = a_rd_r;
        mac_b = wrap ? lb : b_rd_r;
      end
      ST_QUOT: begin
        mac_ctrl.mode = pmm_pkg::MODE_UU;
        mac_a = g1_rd_r;
        mac_b = r_rd_r[W-1:0];
      end
      default: begin
        mac_ctrl.mode = pmm_pkg::MODE_SU;
        mac_a = g_rd_r;
        mac_b = t_rd_r;
      end
    endcase
  end

  pmm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .opa   (mac_a),
    .opb   (mac_b),
    .done  (mac_done),
    .prod  (mac_prod)
  );

  // lambda register
  always_ff @(posedge clk) begin
    if (!rst_n) lam_r <= 16'd2;
    else if (cfg_we) lam_r <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_PROD;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_kind == pmm_pkg::KIND_START) begin
            step_r  <= ST_PROD;
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LAM;
        S_LAM: begin
          // seed the accumulator on the first term
          if (j_r == '0) acc_r <= (step_r == ST_RED) ? r_rd_r : '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            acc_r <= acc_r + mac_prod;
            if (j_r == LAST) begin
              state_r <= S_ENDI;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_ENDI: begin
          j_r <= '0;
          if (step_r == ST_RED) begin
            out_valid_r <= 1'b1;
            out_index_r <= 3'(i_r);
            out_value_r <= acc_r[2*W-1:W];
            out_last_r  <= (i_r == LAST);
            state_r     <= S_OUT;
          end else begin
            state_r <= S_RD;
            if (i_r == LAST) begin
              i_r    <= '0;
              step_r <= (step_r == ST_PROD) ? ST_QUOT : ST_RED;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (i_r == LAST) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
